// File: rtl/core/phc_pkg.sv
// ----------------------------------------------------------------------------
// phc_pkg
// Shared types and constants of the pan stepper homing controller.
// ----------------------------------------------------------------------------
`default_nettype none

package phc_pkg;

  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned CFG_BITS          = 12;
  localparam int unsigned SEARCH_BITS       = CFG_BITS + 1;
  localparam int unsigned OUT_POS_BITS      = 16;
  localparam int unsigned CFG_INDEX_BITS    = 1;

  localparam logic [CFG_BITS-1:0] QUARTER_TURN_RST = 12'd512;
  localparam logic [CFG_BITS-1:0] HOME_OFFSET_RST  = 12'd100;

  localparam logic [7:0] CHR_LF       = 8'h0A;
  localparam logic [7:0] CHR_CR       = 8'h0D;
  localparam logic [7:0] CHR_SPACE    = 8'h20;
  localparam logic [7:0] CHR_QUERY    = 8'h3F;
  localparam logic [7:0] CHR_A        = 8'h41;
  localparam logic [7:0] CHR_D        = 8'h44;
  localparam logic [7:0] CHR_H        = 8'h48;
  localparam logic [7:0] CHR_L        = 8'h4C;
  localparam logic [7:0] CHR_P        = 8'h50;
  localparam logic [7:0] CHR_R        = 8'h52;
  localparam logic [7:0] CHR_S        = 8'h53;
  localparam logic [7:0] CHR_W        = 8'h57;
  localparam logic [7:0] CHR_LOWER_A  = 8'h61;
  localparam logic [7:0] CHR_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CHR_CASE_GAP = 8'h20;

  localparam logic [7:0] PINS_FWD   = 8'h5A;
  localparam logic [7:0] PINS_BACK  = 8'hA5;
  localparam logic [7:0] PINS_LEFT  = 8'h69;
  localparam logic [7:0] PINS_RIGHT = 8'h96;
  localparam logic [7:0] PINS_OFF   = 8'h00;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_QUARTER_TURN = 1'b0,
    CFG_HOME_OFFSET  = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    CMD_EOL,
    CMD_FWD,
    CMD_BACK,
    CMD_LEFT,
    CMD_RIGHT,
    CMD_STOP,
    CMD_PAN_L,
    CMD_PAN_R,
    CMD_HOME,
    CMD_AUTO,
    CMD_QUERY,
    CMD_UNKNOWN
  } cmd_t;

  typedef enum logic [2:0] {
    STS_NONE      = 3'd0,
    STS_HOMED_NEG = 3'd1,
    STS_HOMED_POS = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_UNKNOWN   = 3'd4,
    STS_DROPPED   = 3'd5
  } status_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] quarter_turn;
    logic [CFG_BITS-1:0] home_offset;
  } cfg_t;

  typedef struct packed {
    logic                          step_pulse;
    logic                          step_positive;
    logic [7:0]                    motor_pins;
    logic signed [OUT_POS_BITS-1:0] position;
    logic                          auto_pan_on;
    logic                          busy;
    status_t                       status;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/phc_decode.sv
// ----------------------------------------------------------------------------
// phc_decode
// Case-folding command byte decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module phc_decode (
  input  wire logic [7:0]  cmd,
  output phc_pkg::cmd_t    kind
);

  logic [7:0] upper;

  assign upper = (cmd >= phc_pkg::CHR_LOWER_A && cmd <= phc_pkg::CHR_LOWER_Z) ?
                 cmd - phc_pkg::CHR_CASE_GAP : cmd;

  always_comb begin
    unique case (upper)
      phc_pkg::CHR_LF,
      phc_pkg::CHR_CR:    kind = phc_pkg::CMD_EOL;
      phc_pkg::CHR_W:     kind = phc_pkg::CMD_FWD;
      phc_pkg::CHR_S:     kind = phc_pkg::CMD_BACK;
      phc_pkg::CHR_A:     kind = phc_pkg::CMD_LEFT;
      phc_pkg::CHR_D:     kind = phc_pkg::CMD_RIGHT;
      phc_pkg::CHR_SPACE: kind = phc_pkg::CMD_STOP;
      phc_pkg::CHR_L:     kind = phc_pkg::CMD_PAN_L;
      phc_pkg::CHR_R:     kind = phc_pkg::CMD_PAN_R;
      phc_pkg::CHR_H:     kind = phc_pkg::CMD_HOME;
      phc_pkg::CHR_P:     kind = phc_pkg::CMD_AUTO;
      phc_pkg::CHR_QUERY: kind = phc_pkg::CMD_QUERY;
      default:            kind = phc_pkg::CMD_UNKNOWN;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/phc_core.sv
// ----------------------------------------------------------------------------
// phc_core
// Motion state and single-tick update: homing search, offset move, manual
// move, command handling and auto-pan bounce.
// ----------------------------------------------------------------------------
`default_nettype none

module phc_core #(
  parameter int unsigned POSITION_BITS = phc_pkg::POSITION_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  wire logic           byte_valid,
  input  wire logic [7:0]     cmd,
  input  wire logic           switch_closed,
  input  wire phc_pkg::cfg_t  cfg,
  output phc_pkg::result_t    res
);

  localparam int unsigned PW = POSITION_BITS;
  localparam int unsigned SB = phc_pkg::SEARCH_BITS;
  localparam int unsigned CB = phc_pkg::CFG_BITS;
  localparam int unsigned EW = ((PW > SB) ? PW : SB) + 1;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NEG,
    MODE_POS,
    MODE_OFFSET,
    MODE_MOVE
  } mode_t;

  mode_t          mode_r,     mode_nxt;
  logic [SB-1:0]  search_r,   search_nxt;
  logic [CB-1:0]  steps_r,    steps_nxt;
  logic           move_pos_r, move_pos_nxt;
  logic [PW-1:0]  pos_r,      pos_nxt;
  logic           sweep_r,    sweep_nxt;
  logic           auto_r,     auto_nxt;
  logic [7:0]     pins_r,     pins_nxt;

  phc_pkg::cmd_t    kind;
  phc_pkg::status_t status;
  logic             pulse;
  logic             dir;
  logic             byte_left;
  logic             pan_ok;
  logic [PW-1:0]    pan_step;
  logic signed [EW-1:0] q_ext;
  logic signed [EW-1:0] neg_q_ext;
  logic signed [EW-1:0] p_ext;
  logic signed [PW-1:0] pos_s;

  phc_decode u_decode (
    .cmd  (cmd),
    .kind (kind)
  );

  assign q_ext     = $signed({{(EW-CB){1'b0}}, cfg.quarter_turn});
  assign neg_q_ext = -q_ext;

  always_comb begin
    mode_nxt     = mode_r;
    search_nxt   = search_r;
    steps_nxt    = steps_r;
    move_pos_nxt = move_pos_r;
    pos_nxt      = pos_r;
    sweep_nxt    = sweep_r;
    auto_nxt     = auto_r;
    pins_nxt     = pins_r;
    status       = phc_pkg::STS_NONE;
    pulse        = 1'b0;
    dir          = 1'b0;
    byte_left    = byte_valid;
    pan_ok       = 1'b1;
    pan_step     = '0;
    p_ext        = '0;

    if (mode_nxt == MODE_NEG) begin
      if (search_nxt >= {1'b0, cfg.quarter_turn}) begin
        mode_nxt   = MODE_POS;
        search_nxt = '0;
      end else if (switch_closed) begin
        pos_nxt  = '0;
        mode_nxt = MODE_IDLE;
        status   = phc_pkg::STS_HOMED_NEG;
      end else begin
        pulse      = 1'b1;
        dir        = 1'b0;
        search_nxt = search_nxt + SB'(1);
      end
    end

    if (mode_nxt == MODE_POS) begin
      if (search_nxt >= {cfg.quarter_turn, 1'b0}) begin
        mode_nxt = MODE_IDLE;
        status   = phc_pkg::STS_NOT_FOUND;
      end else if (switch_closed) begin
        if (cfg.home_offset == '0) begin
          pos_nxt  = '0;
          mode_nxt = MODE_IDLE;
          status   = phc_pkg::STS_HOMED_POS;
        end else begin
          mode_nxt  = MODE_OFFSET;
          steps_nxt = cfg.home_offset;
        end
      end else begin
        pulse      = 1'b1;
        dir        = 1'b1;
        search_nxt = search_nxt + SB'(1);
      end
    end else if (mode_nxt == MODE_OFFSET) begin
      if (steps_nxt != '0) begin
        pulse     = 1'b1;
        dir       = 1'b1;
        steps_nxt = steps_nxt - CB'(1);
      end
      if (steps_nxt == '0) begin
        pos_nxt  = '0;
        mode_nxt = MODE_IDLE;
        status   = phc_pkg::STS_HOMED_POS;
      end
    end else if (mode_nxt == MODE_MOVE) begin
      if (steps_nxt != '0) begin
        pulse     = 1'b1;
        dir       = move_pos_r;
        pos_nxt   = pos_nxt + (move_pos_r ? PW'(1) : {PW{1'b1}});
        steps_nxt = steps_nxt - CB'(1);
      end
      if (steps_nxt == '0) begin
        mode_nxt = MODE_IDLE;
      end
    end else if (mode_nxt == MODE_IDLE) begin
      if (byte_left) begin
        case (kind)
          phc_pkg::CMD_EOL:   pan_ok   = 1'b0;
          phc_pkg::CMD_FWD:   pins_nxt = phc_pkg::PINS_FWD;
          phc_pkg::CMD_BACK:  pins_nxt = phc_pkg::PINS_BACK;
          phc_pkg::CMD_LEFT:  pins_nxt = phc_pkg::PINS_LEFT;
          phc_pkg::CMD_RIGHT: pins_nxt = phc_pkg::PINS_RIGHT;
          phc_pkg::CMD_STOP:  pins_nxt = phc_pkg::PINS_OFF;
          phc_pkg::CMD_PAN_L,
          phc_pkg::CMD_PAN_R: begin
            auto_nxt     = 1'b0;
            mode_nxt     = MODE_MOVE;
            move_pos_nxt = (kind == phc_pkg::CMD_PAN_R);
            steps_nxt    = cfg.quarter_turn;
          end
          phc_pkg::CMD_HOME: begin
            auto_nxt   = 1'b0;
            mode_nxt   = MODE_NEG;
            search_nxt = '0;
          end
          phc_pkg::CMD_AUTO: begin
            auto_nxt = ~auto_nxt;
            if (auto_nxt) begin
              sweep_nxt = 1'b0;
            end
            mode_nxt   = MODE_NEG;
            search_nxt = '0;
          end
          phc_pkg::CMD_QUERY: pan_ok = 1'b1;
          default:            status = phc_pkg::STS_UNKNOWN;
        endcase
        byte_left = 1'b0;
      end
      if (pan_ok && auto_nxt && mode_nxt == MODE_IDLE) begin
        pulse    = 1'b1;
        dir      = sweep_nxt;
        pan_step = pos_nxt + (sweep_nxt ? PW'(1) : {PW{1'b1}});
        pos_nxt  = pan_step;
        p_ext    = EW'($signed(pos_nxt));
        if (p_ext <= neg_q_ext) begin
          pos_nxt   = neg_q_ext[PW-1:0];
          sweep_nxt = 1'b1;
        end
        p_ext = EW'($signed(pos_nxt));
        if (p_ext >= q_ext) begin
          pos_nxt   = q_ext[PW-1:0];
          sweep_nxt = 1'b0;
        end
      end
    end

    if (byte_left && status == phc_pkg::STS_NONE) begin
      status = phc_pkg::STS_DROPPED;
    end
  end

  assign pos_s = $signed(pos_nxt);

  always_comb begin
    res.step_pulse    = pulse;
    res.step_positive = pulse & dir;
    res.motor_pins    = pins_nxt;
    res.position      = phc_pkg::OUT_POS_BITS'(pos_s);
    res.auto_pan_on   = auto_nxt;
    res.busy          = (mode_nxt != MODE_IDLE);
    res.status        = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_NEG;
      search_r   <= '0;
      steps_r    <= '0;
      move_pos_r <= 1'b0;
      pos_r      <= '0;
      sweep_r    <= 1'b0;
      auto_r     <= 1'b0;
      pins_r     <= '0;
    end else if (adv) begin
      mode_r     <= mode_nxt;
      search_r   <= search_nxt;
      steps_r    <= steps_nxt;
      move_pos_r <= move_pos_nxt;
      pos_r      <= pos_nxt;
      sweep_r    <= sweep_nxt;
      auto_r     <= auto_nxt;
      pins_r     <= pins_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/pan_stepper_homing_controller.sv
// ----------------------------------------------------------------------------
// pan_stepper_homing_controller
// Pan stepper controller with homing switch search, auto-pan and H-bridge
// command decoding; one tick in, one result out.
// ----------------------------------------------------------------------------
// Each accepted transaction is one step tick and yields exactly one result.
// A tick is taken every clock cycle while in_stall is low; the tick sits in
// an input register, its whole update is done in one combinational pass, and
// the result lands in an output register, where it is valid and can be
// taken at the following edge. While a result waits under out_stall the
// input register still takes one more tick; further ticks are stalled until
// the result is taken.
// Configuration writes are always ready and must only happen while idle.
// Reset leaves the block homing on the negative side.
`default_nettype none

module pan_stepper_homing_controller #(
  parameter int unsigned POSITION_BITS = phc_pkg::POSITION_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,

  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_byte_valid,
  input  wire logic [7:0]                          in_cmd,
  input  wire logic                                in_switch_closed,

  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_step_pulse,
  output logic                                     out_step_positive,
  output logic [7:0]                               out_motor_pins,
  output logic signed [phc_pkg::OUT_POS_BITS-1:0]  out_position,
  output logic                                     out_auto_pan_on,
  output logic                                     out_busy_res,
  output logic [2:0]                               out_status,

  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [phc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [phc_pkg::CFG_BITS-1:0]        cfg_data
);

  logic              in_valid_r;
  logic              byte_valid_r;
  logic [7:0]        cmd_r;
  logic              switch_r;
  logic              out_valid_r;
  phc_pkg::result_t  res;
  phc_pkg::result_t  res_r;
  phc_pkg::cfg_t     cfg_r;
  logic              adv;
  logic              in_take;

  assign adv       = in_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall  = in_valid_r & ~adv;
  assign in_take   = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r         <= 1'b0;
      out_valid_r        <= 1'b0;
      cfg_r.quarter_turn <= phc_pkg::QUARTER_TURN_RST;
      cfg_r.home_offset  <= phc_pkg::HOME_OFFSET_RST;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (phc_pkg::cfg_reg_t'(cfg_index))
          phc_pkg::CFG_QUARTER_TURN: cfg_r.quarter_turn <= cfg_data;
          phc_pkg::CFG_HOME_OFFSET:  cfg_r.home_offset  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_valid_r <= in_byte_valid;
      cmd_r        <= in_cmd;
      switch_r     <= in_switch_closed;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  phc_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .byte_valid    (byte_valid_r),
    .cmd           (cmd_r),
    .switch_closed (switch_r),
    .cfg           (cfg_r),
    .res           (res)
  );

  assign out_valid         = out_valid_r;
  assign out_step_pulse    = res_r.step_pulse;
  assign out_step_positive = res_r.step_positive;
  assign out_motor_pins    = res_r.motor_pins;
  assign out_position      = res_r.position;
  assign out_auto_pan_on   = res_r.auto_pan_on;
  assign out_busy_res      = res_r.busy;
  assign out_status        = res_r.status;

  a_dir_needs_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_step_pulse || !out_step_positive))
    else $error("step direction set without a step");

  a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result side is free");

  a_tick_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !out_valid_r) |=> out_valid)
    else $error("held tick did not produce a result");

endmodule

`default_nettype wire
